// ===== rtl/gclp_pkg.sv =====
// gclp_pkg: shared types, character codes and constants of the g-code line parser
// no dependencies; used by every rtl module

package gclp_pkg;

  // fixed-point scaling of word values: units of 10^-FRACTION_DIGITS
  localparam int FRACTION_DIGITS = 3;
  localparam int FD_W = (FRACTION_DIGITS == 0) ? 1 : $clog2(FRACTION_DIGITS + 1);
  localparam int SCALE_W = $clog2((10 ** FRACTION_DIGITS) + 1);

  // depth of the token queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = (QUEUE_DEPTH <= 1) ? 1 : $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UZ    = 8'd90;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LZ    = 8'd122;
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_X     = 8'd88;
  localparam logic [7:0] CH_Y     = 8'd89;
  localparam logic [7:0] CH_Z     = 8'd90;
  localparam logic [7:0] CH_E     = 8'd69;
  localparam logic [7:0] CH_F     = 8'd70;
  localparam logic [7:0] CH_S     = 8'd83;

  // slots of the word value store
  localparam int NUM_WORDS = 6;
  localparam logic [2:0] SLOT_X = 3'd0;
  localparam logic [2:0] SLOT_Y = 3'd1;
  localparam logic [2:0] SLOT_Z = 3'd2;
  localparam logic [2:0] SLOT_E = 3'd3;
  localparam logic [2:0] SLOT_F = 3'd4;
  localparam logic [2:0] SLOT_S = 3'd5;

  // saturation limits
  localparam logic [31:0] CAP_WORD = 32'h8000_0000;
  localparam logic [31:0] CAP_CODE = 32'h0000_8000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [15:0] CODE_MAX = 16'h7FFF;

  // character classes passed from front to back
  typedef enum logic [2:0] {
    TK_EOL,
    TK_LETTER,
    TK_DIGIT,
    TK_SIGN,
    TK_POINT,
    TK_BLANK,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;     // upper-cased character
  } token_t;

  // line parse phase
  typedef enum logic [1:0] {
    PH_START,
    PH_CODE,
    PH_WORDS,
    PH_BAD
  } phase_t;

  // scale factors 10^k for k = 0 .. FRACTION_DIGITS
  typedef logic [SCALE_W-1:0] pow_tab_t [FRACTION_DIGITS+1];

  function automatic pow_tab_t pow10_tab();
    pow_tab_t    t;
    int unsigned p;
    p = 1;
    for (int i = 0; i <= FRACTION_DIGITS; i++) begin
      t[i] = SCALE_W'(p);
      p = p * 10;
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = pow10_tab();

endpackage

// ===== rtl/gclp_char_if.sv =====
// gclp_char_if: character input channel, valid/ready with one received character
// depends on nothing

interface gclp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/gclp_cmd_if.sv =====
// gclp_cmd_if: parsed command output channel, valid/ready with the command fields
// depends on nothing

interface gclp_cmd_if;
  logic               valid;
  logic               ready;
  logic               cmd_ok;
  logic               is_m_code;
  logic signed [15:0] code_number;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;
  logic signed [31:0] e_value;
  logic signed [31:0] feed_value;
  logic signed [31:0] dwell_value;
  logic [3:0]         axis_present;

  modport source (output valid, output cmd_ok, output is_m_code, output code_number,
                  output x_value, output y_value, output z_value, output e_value,
                  output feed_value, output dwell_value, output axis_present,
                  input ready);
  modport sink (input valid, input cmd_ok, input is_m_code, input code_number,
                input x_value, input y_value, input z_value, input e_value,
                input feed_value, input dwell_value, input axis_present,
                output ready);
endinterface

// ===== rtl/gclp_front.sv =====
// gclp_front: accepts characters, drops spaces and line feeds, upper-cases letters
// and classifies each kept character into a token; depends on gclp_pkg, gclp_char_if

module gclp_front (
  gclp_char_if.sink       char_in,
  input  logic            queue_full,
  output logic            tok_push,
  output gclp_pkg::token_t tok
);

  logic [7:0] ch_up;
  logic       dropped;

  // accept whenever the queue has room
  assign char_in.ready = !queue_full;

  // spaces and line feeds never reach the back end
  assign dropped  = (char_in.char_code == gclp_pkg::CH_LF) ||
                    (char_in.char_code == gclp_pkg::CH_SPACE);
  assign tok_push = char_in.valid && char_in.ready && !dropped;

  // upper-case a..z
  always_comb begin
    if (char_in.char_code >= gclp_pkg::CH_LA && char_in.char_code <= gclp_pkg::CH_LZ) begin
      ch_up = char_in.char_code - gclp_pkg::CASE_OFS;
    end else begin
      ch_up = char_in.char_code;
    end
  end

  // classify
  always_comb begin
    tok.ch = ch_up;
    priority if (ch_up == gclp_pkg::CH_CR) begin
      tok.kind = gclp_pkg::TK_EOL;
    end else if (ch_up >= gclp_pkg::CH_UA && ch_up <= gclp_pkg::CH_UZ) begin
      tok.kind = gclp_pkg::TK_LETTER;
    end else if (ch_up >= gclp_pkg::CH_0 && ch_up <= gclp_pkg::CH_9) begin
      tok.kind = gclp_pkg::TK_DIGIT;
    end else if (ch_up == gclp_pkg::CH_PLUS || ch_up == gclp_pkg::CH_MINUS) begin
      tok.kind = gclp_pkg::TK_SIGN;
    end else if (ch_up == gclp_pkg::CH_POINT) begin
      tok.kind = gclp_pkg::TK_POINT;
    end else if (ch_up == gclp_pkg::CH_TAB || ch_up == gclp_pkg::CH_VT ||
                 ch_up == gclp_pkg::CH_FF) begin
      tok.kind = gclp_pkg::TK_BLANK;
    end else begin
      tok.kind = gclp_pkg::TK_OTHER;
    end
  end

endmodule

// ===== rtl/gclp_queue.sv =====
// gclp_queue: small token fifo that decouples the front end from the back end
// depends on gclp_pkg

module gclp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gclp_pkg::token_t push_data,
  output logic             full,
  input  logic             pop,
  output gclp_pkg::token_t pop_data,
  output logic             empty
);

  gclp_pkg::token_t               entries [gclp_pkg::QUEUE_DEPTH];
  logic [gclp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [gclp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [gclp_pkg::QCNT_W-1:0]    count;

  assign full     = (count == gclp_pkg::QCNT_W'(gclp_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gclp_pkg::QPTR_W'(gclp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gclp_pkg::QPTR_W'(gclp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/gclp_back.sv =====
// gclp_back: line parse engine; takes one queued token a cycle, holding an end of line until
// cmd_out is free; builds code and word values, registers one command per line; depends on gclp_pkg, gclp_cmd_if

module gclp_back (
  input  logic             clk,
  input  logic             rst,
  input  gclp_pkg::token_t tok,
  input  logic             tok_valid,
  output logic             tok_pop,
  gclp_cmd_if.source       cmd_out
);

  localparam int PROD_W = 32 + gclp_pkg::SCALE_W;

  // line state
  gclp_pkg::phase_t          phase, phase_next;
  logic                      line_is_m, line_is_m_next;
  logic [15:0]               code_accum, code_accum_next;
  logic [7:0]                word_letter, word_letter_next;
  logic                      word_has_body, word_has_body_next;
  logic [31:0]               number_accum, number_accum_next;
  logic                      number_negative, number_negative_next;
  logic                      number_started, number_started_next;
  logic                      seen_point, seen_point_next;
  logic [gclp_pkg::FD_W-1:0] fraction_digits, fraction_digits_next;
  logic                      number_stopped, number_stopped_next;
  logic [31:0]               word_values [gclp_pkg::NUM_WORDS];
  logic [31:0]               word_values_next [gclp_pkg::NUM_WORDS];
  logic [3:0]                present_bits, present_bits_next;

  // datapath helpers
  logic                      is_eol;
  logic                      take;
  logic                      feed_en;
  logic                      feed_decimal;
  logic                      clear_num;
  logic                      commit_en;
  logic [31:0]               cap_sel;
  logic [35:0]               push_sum;
  logic [31:0]               pushed;
  logic [15:0]               code_value;
  logic [gclp_pkg::FD_W-1:0] scale_idx;
  logic [PROD_W-1:0]         scaled;
  logic [31:0]               word_mag;
  logic [31:0]               word_value;
  logic                      slot_hit;
  logic [2:0]                slot;
  logic [31:0]               words_done [gclp_pkg::NUM_WORDS];
  logic [3:0]                present_done;
  logic                      line_ok;

  assign is_eol  = (tok.kind == gclp_pkg::TK_EOL);
  // an end of line needs the output register free; other tokens always go
  assign take    = tok_valid && (!is_eol || !cmd_out.valid || cmd_out.ready);
  assign tok_pop = take;

  // accumulate one digit with saturation at the active cap
  assign cap_sel  = (phase == gclp_pkg::PH_WORDS) ? gclp_pkg::CAP_WORD : gclp_pkg::CAP_CODE;
  assign push_sum = {4'd0, number_accum} * 36'd10 + {32'd0, tok.ch[3:0]};
  assign pushed   = (push_sum > {4'd0, cap_sel}) ? cap_sel : push_sum[31:0];

  // signed code from the accumulated magnitude
  always_comb begin
    if (number_negative) begin
      code_value = 16'd0 - number_accum[15:0];
    end else if (number_accum > {16'd0, gclp_pkg::CODE_MAX}) begin
      code_value = gclp_pkg::CODE_MAX;
    end else begin
      code_value = number_accum[15:0];
    end
  end

  // word value: scale missing fraction digits in one multiply, then saturate
  assign scale_idx = gclp_pkg::FD_W'(gclp_pkg::FRACTION_DIGITS) - fraction_digits;
  assign scaled    = PROD_W'(number_accum) * PROD_W'(gclp_pkg::POW10[scale_idx]);
  assign word_mag  = (scaled > PROD_W'(gclp_pkg::CAP_WORD)) ? gclp_pkg::CAP_WORD
                                                            : scaled[31:0];
  always_comb begin
    if (number_negative) begin
      word_value = 32'd0 - word_mag;
    end else if (word_mag > gclp_pkg::WORD_MAX) begin
      word_value = gclp_pkg::WORD_MAX;
    end else begin
      word_value = word_mag;
    end
  end

  // map the word letter to its slot
  always_comb begin
    slot_hit = 1'b1;
    slot     = gclp_pkg::SLOT_X;
    unique case (word_letter)
      gclp_pkg::CH_X: slot = gclp_pkg::SLOT_X;
      gclp_pkg::CH_Y: slot = gclp_pkg::SLOT_Y;
      gclp_pkg::CH_Z: slot = gclp_pkg::SLOT_Z;
      gclp_pkg::CH_E: slot = gclp_pkg::SLOT_E;
      gclp_pkg::CH_F: slot = gclp_pkg::SLOT_F;
      gclp_pkg::CH_S: slot = gclp_pkg::SLOT_S;
      default:        slot_hit = 1'b0;
    endcase
  end

  // word store with the pending word folded in
  assign commit_en = take && (phase == gclp_pkg::PH_WORDS) &&
                     ((tok.kind == gclp_pkg::TK_LETTER) || (is_eol && word_has_body));
  always_comb begin
    present_done = present_bits;
    for (int i = 0; i < gclp_pkg::NUM_WORDS; i++) begin
      words_done[i] = word_values[i];
      if (commit_en && slot_hit && slot == 3'(i)) begin
        words_done[i] = word_value;
      end
    end
    if (commit_en && slot_hit && slot <= gclp_pkg::SLOT_E) begin
      present_done[slot[1:0]] = 1'b1;
    end
  end

  assign line_ok = (phase == gclp_pkg::PH_CODE) || (phase == gclp_pkg::PH_WORDS);

  // next line state
  always_comb begin
    phase_next           = phase;
    line_is_m_next       = line_is_m;
    code_accum_next      = code_accum;
    word_letter_next     = word_letter;
    word_has_body_next   = word_has_body;
    number_accum_next    = number_accum;
    number_negative_next = number_negative;
    number_started_next  = number_started;
    seen_point_next      = seen_point;
    fraction_digits_next = fraction_digits;
    number_stopped_next  = number_stopped;
    present_bits_next    = present_done;
    for (int i = 0; i < gclp_pkg::NUM_WORDS; i++) begin
      word_values_next[i] = words_done[i];
    end
    feed_en      = 1'b0;
    feed_decimal = (phase == gclp_pkg::PH_WORDS);
    clear_num    = 1'b0;

    if (take && is_eol) begin
      // end of line: back to a clean line
      phase_next         = gclp_pkg::PH_START;
      line_is_m_next     = 1'b0;
      code_accum_next    = '0;
      word_letter_next   = '0;
      word_has_body_next = 1'b0;
      clear_num          = 1'b1;
      present_bits_next  = '0;
      for (int i = 0; i < gclp_pkg::NUM_WORDS; i++) begin
        word_values_next[i] = '0;
      end
    end else if (take) begin
      unique case (phase)
        gclp_pkg::PH_START: begin
          if (tok.ch == gclp_pkg::CH_G || tok.ch == gclp_pkg::CH_M) begin
            line_is_m_next = (tok.ch == gclp_pkg::CH_M);
            phase_next     = gclp_pkg::PH_CODE;
            clear_num      = 1'b1;
          end else begin
            phase_next = gclp_pkg::PH_BAD;
          end
        end
        gclp_pkg::PH_CODE: begin
          if (tok.kind == gclp_pkg::TK_LETTER) begin
            code_accum_next    = code_value;
            phase_next         = gclp_pkg::PH_WORDS;
            word_letter_next   = tok.ch;
            word_has_body_next = 1'b0;
            clear_num          = 1'b1;
          end else begin
            feed_en = 1'b1;
          end
        end
        gclp_pkg::PH_WORDS: begin
          if (tok.kind == gclp_pkg::TK_LETTER) begin
            word_letter_next   = tok.ch;
            word_has_body_next = 1'b0;
            clear_num          = 1'b1;
          end else begin
            word_has_body_next = 1'b1;
            feed_en            = 1'b1;
          end
        end
        gclp_pkg::PH_BAD: begin
        end
      endcase
    end

    // number syntax step
    if (clear_num) begin
      number_accum_next    = '0;
      number_negative_next = 1'b0;
      number_started_next  = 1'b0;
      seen_point_next      = 1'b0;
      fraction_digits_next = '0;
      number_stopped_next  = 1'b0;
    end else if (feed_en && !number_stopped) begin
      unique case (tok.kind)
        gclp_pkg::TK_BLANK: begin
          if (number_started) begin
            number_stopped_next = 1'b1;
          end
        end
        gclp_pkg::TK_SIGN: begin
          if (number_started) begin
            number_stopped_next = 1'b1;
          end else begin
            number_started_next  = 1'b1;
            number_negative_next = (tok.ch == gclp_pkg::CH_MINUS);
          end
        end
        gclp_pkg::TK_DIGIT: begin
          number_started_next = 1'b1;
          if (!seen_point) begin
            number_accum_next = pushed;
          end else if (fraction_digits < gclp_pkg::FD_W'(gclp_pkg::FRACTION_DIGITS)) begin
            fraction_digits_next = fraction_digits + 1'b1;
            number_accum_next    = pushed;
          end
        end
        gclp_pkg::TK_POINT: begin
          if (feed_decimal && !seen_point) begin
            number_started_next = 1'b1;
            seen_point_next     = 1'b1;
          end else begin
            number_stopped_next = 1'b1;
          end
        end
        default: number_stopped_next = 1'b1;
      endcase
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= gclp_pkg::PH_START;
      line_is_m       <= 1'b0;
      code_accum      <= '0;
      word_letter     <= '0;
      word_has_body   <= 1'b0;
      number_accum    <= '0;
      number_negative <= 1'b0;
      number_started  <= 1'b0;
      seen_point      <= 1'b0;
      fraction_digits <= '0;
      number_stopped  <= 1'b0;
      present_bits    <= '0;
      for (int i = 0; i < gclp_pkg::NUM_WORDS; i++) begin
        word_values[i] <= '0;
      end
    end else begin
      phase           <= phase_next;
      line_is_m       <= line_is_m_next;
      code_accum      <= code_accum_next;
      word_letter     <= word_letter_next;
      word_has_body   <= word_has_body_next;
      number_accum    <= number_accum_next;
      number_negative <= number_negative_next;
      number_started  <= number_started_next;
      seen_point      <= seen_point_next;
      fraction_digits <= fraction_digits_next;
      number_stopped  <= number_stopped_next;
      present_bits    <= present_bits_next;
      for (int i = 0; i < gclp_pkg::NUM_WORDS; i++) begin
        word_values[i] <= word_values_next[i];
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid <= 1'b0;
    end else if (take && is_eol) begin
      cmd_out.valid <= 1'b1;
    end else if (cmd_out.ready) begin
      cmd_out.valid <= 1'b0;
    end
  end

  // output payload, zeroed for a bad line
  always_ff @(posedge clk) begin
    if (take && is_eol) begin
      cmd_out.cmd_ok       <= line_ok;
      cmd_out.is_m_code    <= line_ok && line_is_m;
      cmd_out.code_number  <= !line_ok ? '0 :
                              (phase == gclp_pkg::PH_CODE) ? code_value : code_accum;
      cmd_out.x_value      <= line_ok ? words_done[gclp_pkg::SLOT_X] : '0;
      cmd_out.y_value      <= line_ok ? words_done[gclp_pkg::SLOT_Y] : '0;
      cmd_out.z_value      <= line_ok ? words_done[gclp_pkg::SLOT_Z] : '0;
      cmd_out.e_value      <= line_ok ? words_done[gclp_pkg::SLOT_E] : '0;
      cmd_out.feed_value   <= line_ok ? words_done[gclp_pkg::SLOT_F] : '0;
      cmd_out.dwell_value  <= line_ok ? words_done[gclp_pkg::SLOT_S] : '0;
      cmd_out.axis_present <= line_ok ? present_done : '0;
    end
  end

  // end of line always returns the parser to the start of a line
  a_eol_restart: assert property (@(posedge clk) disable iff (rst)
    (take && is_eol) |=> (phase == gclp_pkg::PH_START))
    else $error("parser not at line start after end of line");

  // a decimal point can only have been taken inside a word
  a_point_in_word: assert property (@(posedge clk) disable iff (rst)
    seen_point |-> (phase == gclp_pkg::PH_WORDS))
    else $error("decimal point recorded outside a word");

  // fraction digit count never passes the kept precision
  a_fraction_bound: assert property (@(posedge clk) disable iff (rst)
    fraction_digits <= gclp_pkg::FD_W'(gclp_pkg::FRACTION_DIGITS))
    else $error("fraction digit count out of range");

  // no axis can be marked before the command letter
  a_clean_start: assert property (@(posedge clk) disable iff (rst)
    (phase == gclp_pkg::PH_START) |-> (present_bits == '0 && !number_started))
    else $error("stale line state at start of line");

  // a new command appears only from an end of line
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_out.valid) |-> $past(take && is_eol))
    else $error("command presented without an end of line");

endmodule

// ===== rtl/gcode_line_parser_unit.sv =====
// gcode_line_parser_unit: top level of the g-code line parser
// depends on gclp_pkg, gclp_char_if, gclp_cmd_if, gclp_front, gclp_queue, gclp_back

// Characters enter on char_in at up to one per clock while the queue has room;
// spaces and line feeds are dropped at the input and the rest are classified and
// queued in a four-entry token queue. The back end takes one token per clock,
// holding a carriage return only while the last command is unread, and does the
// digit accumulate and word commit (one constant multiply for the fraction
// scaling) as each token is taken. A carriage return passes the token queue
// and the back end registers one command for it on cmd_out; the next line is
// accepted while that command waits, and input stalls only once the queue fills
// behind an unread command. No clearing pass is needed after reset.

module gcode_line_parser_unit (
  input  logic        clk,
  input  logic        rst,
  gclp_char_if.sink   char_in,
  gclp_cmd_if.source  cmd_out
);

  gclp_pkg::token_t front_tok;
  gclp_pkg::token_t back_tok;
  logic             tok_push;
  logic             tok_pop;
  logic             queue_full;
  logic             queue_empty;

  // classify incoming characters
  gclp_front u_front (
    .char_in    (char_in),
    .queue_full (queue_full),
    .tok_push   (tok_push),
    .tok        (front_tok)
  );

  // token queue between front and back
  gclp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_push),
    .push_data (front_tok),
    .full      (queue_full),
    .pop       (tok_pop),
    .pop_data  (back_tok),
    .empty     (queue_empty)
  );

  // parse engine and command register
  gclp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (back_tok),
    .tok_valid (!queue_empty),
    .tok_pop   (tok_pop),
    .cmd_out   (cmd_out)
  );

endmodule

// ===== bench/tb_gcode_line_parser_unit.sv =====
// tb_gcode_line_parser_unit: self-checking bench for the g-code line parser
// depends on gclp_pkg, gclp_char_if, gclp_cmd_if and gcode_line_parser_unit
// directed lines, then random lines, checked against typed expectations or an in-bench line predictor

`timescale 1ns / 100ps

module tb_gcode_line_parser_unit;

  // one parsed command as it leaves the block
  typedef struct packed {
    logic        ok;
    logic        m_code;
    logic [15:0] code;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] e;
    logic [31:0] feed;
    logic [31:0] dwell;
    logic [3:0]  axes;
  } cmd_t;

  localparam int RANDOM_CHARS = 850;

  logic clk;
  logic rst;

  gclp_char_if char_bus();
  gclp_cmd_if  cmd_bus();

  gcode_line_parser_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_bus),
    .cmd_out (cmd_bus)
  );

  // line predictor state
  gclp_pkg::phase_t ln_phase;
  logic        ln_m;
  logic [15:0] ln_code;
  logic [7:0]  wd_letter;
  logic        wd_body;
  logic [31:0] num_mag;
  logic        num_neg;
  logic        num_started;
  logic        num_point;
  logic        num_stop;
  int          num_frac;
  logic [31:0] wd_val [gclp_pkg::NUM_WORDS];
  logic [3:0]  axes_seen;

  // bench bookkeeping
  cmd_t        pending_cmds[$];
  logic [7:0]  line_chars[$];
  string       row_text[$];
  bit          row_typed[$];
  cmd_t        row_want[$];
  int          fail_count;
  int          cmds_seen;
  int          kept_chars;
  int          rdy_left;
  bit          rdy_level;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_number();
    num_mag = '0;
    num_neg = 1'b0;
    num_started = 1'b0;
    num_point = 1'b0;
    num_frac = 0;
    num_stop = 1'b0;
  endfunction

  function automatic void clear_line();
    ln_phase = gclp_pkg::PH_START;
    ln_m = 1'b0;
    ln_code = '0;
    wd_letter = '0;
    wd_body = 1'b0;
    clear_number();
    foreach (wd_val[i]) wd_val[i] = '0;
    axes_seen = '0;
  endfunction

  // accumulate one digit, clamped at the cap
  function automatic void push_digit(logic [7:0] d, logic [31:0] cap);
    logic [63:0] t;
    t = {32'd0, num_mag} * 64'd10 + {56'd0, d};
    num_mag = (t > {32'd0, cap}) ? cap : t[31:0];
  endfunction

  function automatic void feed_number(logic [7:0] c, bit decimal, logic [31:0] cap);
    if (num_stop) return;
    if (!num_started && (c == gclp_pkg::CH_TAB || c == gclp_pkg::CH_VT ||
                         c == gclp_pkg::CH_FF)) return;
    if (!num_started && (c == gclp_pkg::CH_PLUS || c == gclp_pkg::CH_MINUS)) begin
      num_started = 1'b1;
      num_neg = (c == gclp_pkg::CH_MINUS);
      return;
    end
    if (c >= gclp_pkg::CH_0 && c <= gclp_pkg::CH_9) begin
      num_started = 1'b1;
      if (!num_point) begin
        push_digit(c - gclp_pkg::CH_0, cap);
      end else if (num_frac < gclp_pkg::FRACTION_DIGITS) begin
        num_frac++;
        push_digit(c - gclp_pkg::CH_0, cap);
      end
      return;
    end
    if (decimal && c == gclp_pkg::CH_POINT && !num_point) begin
      num_started = 1'b1;
      num_point = 1'b1;
      return;
    end
    num_stop = 1'b1;
  endfunction

  // word value in thousandths, missing fraction digits scaled in
  function automatic logic [31:0] scaled_word();
    logic [63:0] mag;
    int          i;
    mag = {32'd0, num_mag};
    for (i = num_frac; i < gclp_pkg::FRACTION_DIGITS; i++) begin
      mag = mag * 64'd10;
      if (mag > {32'd0, gclp_pkg::CAP_WORD}) mag = {32'd0, gclp_pkg::CAP_WORD};
    end
    if (num_neg) return 32'd0 - mag[31:0];
    return (mag > {32'd0, gclp_pkg::WORD_MAX}) ? gclp_pkg::WORD_MAX : mag[31:0];
  endfunction

  function automatic logic [15:0] code_value();
    logic [31:0] t;
    if (num_neg) begin
      t = 32'h0001_0000 - num_mag;
      return t[15:0];
    end
    return (num_mag > {16'd0, gclp_pkg::CODE_MAX}) ? gclp_pkg::CODE_MAX : num_mag[15:0];
  endfunction

  function automatic void store_word();
    logic [31:0] v;
    v = scaled_word();
    case (wd_letter)
      gclp_pkg::CH_X: begin
        wd_val[gclp_pkg::SLOT_X] = v;
        axes_seen[gclp_pkg::SLOT_X] = 1'b1;
      end
      gclp_pkg::CH_Y: begin
        wd_val[gclp_pkg::SLOT_Y] = v;
        axes_seen[gclp_pkg::SLOT_Y] = 1'b1;
      end
      gclp_pkg::CH_Z: begin
        wd_val[gclp_pkg::SLOT_Z] = v;
        axes_seen[gclp_pkg::SLOT_Z] = 1'b1;
      end
      gclp_pkg::CH_E: begin
        wd_val[gclp_pkg::SLOT_E] = v;
        axes_seen[gclp_pkg::SLOT_E] = 1'b1;
      end
      gclp_pkg::CH_F: wd_val[gclp_pkg::SLOT_F] = v;
      gclp_pkg::CH_S: wd_val[gclp_pkg::SLOT_S] = v;
      default: ;
    endcase
  endfunction

  function automatic void open_word(logic [7:0] c);
    wd_letter = c;
    wd_body = 1'b0;
    clear_number();
  endfunction

  // advance the predictor by one character; returns 1 when a command is due
  function automatic bit predict_char(input logic [7:0] raw, output cmd_t res);
    logic [7:0] c;
    bit         is_letter;
    bit         ok;
    res = '0;
    c = raw;
    if (c == gclp_pkg::CH_LF || c == gclp_pkg::CH_SPACE) return 1'b0;
    if (c == gclp_pkg::CH_CR) begin
      ok = (ln_phase == gclp_pkg::PH_CODE || ln_phase == gclp_pkg::PH_WORDS);
      if (ln_phase == gclp_pkg::PH_CODE) ln_code = code_value();
      if (ln_phase == gclp_pkg::PH_WORDS && wd_body) store_word();
      if (ok) begin
        res.ok = 1'b1;
        res.m_code = ln_m;
        res.code = ln_code;
        res.x = wd_val[gclp_pkg::SLOT_X];
        res.y = wd_val[gclp_pkg::SLOT_Y];
        res.z = wd_val[gclp_pkg::SLOT_Z];
        res.e = wd_val[gclp_pkg::SLOT_E];
        res.feed = wd_val[gclp_pkg::SLOT_F];
        res.dwell = wd_val[gclp_pkg::SLOT_S];
        res.axes = axes_seen;
      end
      clear_line();
      return 1'b1;
    end
    if (c >= gclp_pkg::CH_LA && c <= gclp_pkg::CH_LZ) c = c - gclp_pkg::CASE_OFS;
    is_letter = (c >= gclp_pkg::CH_UA && c <= gclp_pkg::CH_UZ);
    case (ln_phase)
      gclp_pkg::PH_START: begin
        if (c == gclp_pkg::CH_G || c == gclp_pkg::CH_M) begin
          ln_m = (c == gclp_pkg::CH_M);
          ln_phase = gclp_pkg::PH_CODE;
          clear_number();
        end else begin
          ln_phase = gclp_pkg::PH_BAD;
        end
      end
      gclp_pkg::PH_CODE: begin
        if (is_letter) begin
          ln_code = code_value();
          ln_phase = gclp_pkg::PH_WORDS;
          open_word(c);
        end else begin
          feed_number(c, 1'b0, gclp_pkg::CAP_CODE);
        end
      end
      gclp_pkg::PH_WORDS: begin
        if (is_letter) begin
          store_word();
          open_word(c);
        end else begin
          wd_body = 1'b1;
          feed_number(c, 1'b1, gclp_pkg::CAP_WORD);
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("command %0d %s: got %h, expected %h",
                                cmds_seen, name, got, want));
  endtask

  task automatic check_cmd();
    cmd_t want;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("command %0d arrived with none expected", cmds_seen));
    end else begin
      want = pending_cmds.pop_front();
      check_field("cmd_ok", {31'd0, cmd_bus.cmd_ok}, {31'd0, want.ok});
      check_field("is_m_code", {31'd0, cmd_bus.is_m_code}, {31'd0, want.m_code});
      check_field("code_number", {16'd0, cmd_bus.code_number}, {16'd0, want.code});
      check_field("x_value", cmd_bus.x_value, want.x);
      check_field("y_value", cmd_bus.y_value, want.y);
      check_field("z_value", cmd_bus.z_value, want.z);
      check_field("e_value", cmd_bus.e_value, want.e);
      check_field("feed_value", cmd_bus.feed_value, want.feed);
      check_field("dwell_value", cmd_bus.dwell_value, want.dwell);
      check_field("axis_present", {28'd0, cmd_bus.axis_present}, {28'd0, want.axes});
    end
    cmds_seen++;
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int sender_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // command side: random ready pattern, check on every transaction
  initial begin
    cmd_bus.ready = 1'b0;
    rdy_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && cmd_bus.valid && cmd_bus.ready) check_cmd();
      if (rdy_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          rdy_level = 1'b0;
          rdy_left = stall_len();
        end else begin
          rdy_level = 1'b1;
          rdy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
        end
      end
      cmd_bus.ready <= rdy_level;
      rdy_left--;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(input logic [7:0] c, input bit burst,
                           output bit made, output cmd_t pred);
    int gap;
    gap = sender_gap(burst);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_bus.valid <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk); while (!char_bus.ready);
    if (c != gclp_pkg::CH_LF && c != gclp_pkg::CH_SPACE) kept_chars++;
    made = predict_char(c, pred);
  endtask

  // send line_chars plus the closing carriage return
  task automatic send_line(input bit typed, input cmd_t want);
    bit   burst;
    bit   made;
    cmd_t pred;
    burst = ($urandom_range(0, 4) == 0);
    line_chars.push_back(gclp_pkg::CH_CR);
    foreach (line_chars[i]) begin
      send_char(line_chars[i], burst, made, pred);
      if (made) pending_cmds.push_back(typed ? want : pred);
    end
    line_chars.delete();
  endtask

  task automatic drain_cmds();
    char_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  function automatic void add_row(string text, bit typed, cmd_t want);
    row_text.push_back(text);
    row_typed.push_back(typed);
    row_want.push_back(want);
  endfunction

  function automatic cmd_t code_only(logic m, logic [15:0] code);
    cmd_t r;
    r = '0;
    r.ok = 1'b1;
    r.m_code = m;
    r.code = code;
    return r;
  endfunction

  function automatic cmd_t x_only(logic [31:0] x);
    cmd_t r;
    r = code_only(1'b0, 16'd1);
    r.x = x;
    r.axes = 4'b0001;
    return r;
  endfunction

  // random line building, with stray blanks that the block drops
  function automatic void put_char(logic [7:0] c);
    if ($urandom_range(0, 15) == 0)
      line_chars.push_back($urandom_range(0, 1) ? gclp_pkg::CH_SPACE : gclp_pkg::CH_LF);
    line_chars.push_back(c);
  endfunction

  function automatic void put_letter(logic [7:0] up);
    put_char($urandom_range(0, 1) ? up + gclp_pkg::CASE_OFS : up);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put_char(gclp_pkg::CH_0 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    return (b >= gclp_pkg::CH_CR) ? b + 8'd1 : b;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 9) < 3) return gclp_pkg::CH_UA + 8'($urandom_range(0, 25));
    case ($urandom_range(0, 5))
      0: return gclp_pkg::CH_X;
      1: return gclp_pkg::CH_Y;
      2: return gclp_pkg::CH_Z;
      3: return gclp_pkg::CH_E;
      4: return gclp_pkg::CH_F;
      default: return gclp_pkg::CH_S;
    endcase
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? gclp_pkg::CH_MINUS : gclp_pkg::CH_PLUS;
  endfunction

  function automatic void build_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      // well-formed command with random words
      put_letter($urandom_range(0, 1) ? gclp_pkg::CH_M : gclp_pkg::CH_G);
      if ($urandom_range(0, 4) == 0) put_char(pick_sign());
      put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3));
      repeat ($urandom_range(0, 5)) begin
        put_letter(pick_letter());
        if ($urandom_range(0, 19) == 0)
          put_char(($urandom_range(0, 2) == 0) ? gclp_pkg::CH_TAB :
                   ($urandom_range(0, 1) ? gclp_pkg::CH_VT : gclp_pkg::CH_FF));
        if ($urandom_range(0, 2) == 0) put_char(pick_sign());
        put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4));
        if ($urandom_range(0, 4) < 3) begin
          put_char(gclp_pkg::CH_POINT);
          put_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 19) == 0) begin
          put_char(noise_byte());
          put_digits($urandom_range(0, 2));
        end
      end
      if ($urandom_range(0, 19) == 0) put_letter(pick_letter());
    end else if (kind < 90) begin
      // broken or empty line
      repeat ($urandom_range(0, 6)) put_char(noise_byte());
    end else begin
      // command followed by garbage
      put_letter($urandom_range(0, 1) ? gclp_pkg::CH_M : gclp_pkg::CH_G);
      repeat ($urandom_range(1, 10)) put_char(noise_byte());
    end
  endfunction

  // ---------------------------------------------------------------- main

  initial begin
    int  base;
    bit  paused;
    rst = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.char_code = '0;
    fail_count = 0;
    cmds_seen = 0;
    kept_chars = 0;
    paused = 1'b0;
    clear_line();

    // directed lines; typed rows carry expectations that are plain to read
    add_row("", 1'b1, '0);
    add_row("G1 X10 Y-2.5 Z0.001 E3 F1500 S7", 1'b0, '0);
    add_row("m104 s215.5", 1'b0, '0);
    add_row("T0", 1'b1, '0);
    add_row("X5 G1", 1'b1, '0);
    add_row("M", 1'b1, code_only(1'b1, 16'd0));
    add_row("G1 X2147483.647", 1'b1, x_only(gclp_pkg::WORD_MAX));
    add_row("G1 X2147483.648", 1'b1, x_only(gclp_pkg::WORD_MAX));
    add_row("G1 X-2147483.648", 1'b1, x_only(gclp_pkg::CAP_WORD));
    add_row("G1 X-99999999999", 1'b1, x_only(gclp_pkg::CAP_WORD));
    add_row("G32767", 1'b1, code_only(1'b0, gclp_pkg::CODE_MAX));
    add_row("G99999", 1'b1, code_only(1'b0, gclp_pkg::CODE_MAX));
    add_row("M-32768", 1'b1, code_only(1'b1, 16'h8000));
    add_row("M-99999", 1'b1, code_only(1'b1, 16'h8000));
    add_row("G-", 1'b0, '0);
    add_row("G1 X1 X2 Q9", 1'b0, '0);
    add_row("G1 XY7", 1'b0, '0);
    add_row("G1 X", 1'b0, '0);
    add_row("G1 X1.23456 E-.5", 1'b0, '0);
    add_row("G1 X\t-1.5 Y1.5.3 Z1#5", 1'b0, '0);
    add_row("g\0132.5 F+\377 S\n9", 1'b0, '0);
    add_row("G0 E\0147 X\0010", 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (row_text[r]) begin
      for (int i = 0; i < row_text[r].len(); i++) line_chars.push_back(row_text[r][i]);
      send_line(row_typed[r], row_want[r]);
    end
    drain_cmds();

    // random lines, with one full drain halfway through
    base = kept_chars;
    while (kept_chars - base < RANDOM_CHARS) begin
      build_random_line();
      send_line(1'b0, '0);
      if (!paused && kept_chars - base >= RANDOM_CHARS / 2) begin
        paused = 1'b1;
        drain_cmds();
      end
    end

    char_bus.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gclp_pkg.sv
rtl/gclp_char_if.sv
rtl/gclp_cmd_if.sv
rtl/gclp_front.sv
rtl/gclp_queue.sv
rtl/gclp_back.sv
rtl/gcode_line_parser_unit.sv
bench/tb_gcode_line_parser_unit.sv
